@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

@@ hw/rtl/sitrd_pkg.sv @@
// ----------------------------------------------------------------------------
// sitrd_pkg
// Types, constants and helper functions for the radix text converter.
// ----------------------------------------------------------------------------
package sitrd_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int MAX_RADIX      = 16;
   localparam int SLOTS          = 16;
   localparam int RADIX_BITS     = 5;
   localparam int DIGIT_BITS     = $clog2(SLOTS);
   localparam int SYM_BITS       = 8;
   localparam int STACK_DEPTH    = VALUE_BITS;
   localparam int CNT_BITS       = $clog2(STACK_DEPTH + 1);
   localparam int PTR_BITS       = $clog2(STACK_DEPTH);
   localparam int STEP_BITS      = $clog2(VALUE_BITS);
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam int HALF_SLOTS     = SLOTS / 2;
   localparam int WORD_BITS      = HALF_SLOTS * SYM_BITS;

   localparam logic [SYM_BITS-1:0] MINUS_SIGN    = 8'h2D;
   localparam logic [SYM_BITS-1:0] PLUS_SIGN     = 8'h2B;
   localparam logic [SYM_BITS-1:0] LOW_PRINTABLE = 8'd32;
   localparam logic [SYM_BITS-1:0] HIGH_LIMIT    = 8'd127;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIGITS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIGITS_HIGH = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctrl_type;

   // Alphabet symbol for a digit value; symbol 0 sits in the lowest byte.
   function automatic logic [SYM_BITS-1:0] symbol_at(
      input logic [WORD_BITS-1:0]  lo,
      input logic [WORD_BITS-1:0]  hi,
      input logic [DIGIT_BITS-1:0] idx
   );
      logic [2*WORD_BITS-1:0] all;
      all = {hi, lo};
      return all[idx*SYM_BITS +: SYM_BITS];
   endfunction

endpackage

@@ hw/rtl/sitrd_alpha_check.sv @@
// ----------------------------------------------------------------------------
// sitrd_alpha_check
// Decides whether the configured digit alphabet is usable.
// ----------------------------------------------------------------------------
module sitrd_alpha_check (
   input  logic [sitrd_pkg::RADIX_BITS-1:0] radix,
   input  logic [sitrd_pkg::WORD_BITS-1:0]  digits_low,
   input  logic [sitrd_pkg::WORD_BITS-1:0]  digits_high,
   output logic                             alpha_ok
);
   import sitrd_pkg::*;

   logic [SYM_BITS-1:0] sym [SLOTS];
   logic                sym_bad;
   logic                dup;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         sym[i] = symbol_at(digits_low, digits_high, DIGIT_BITS'(i));
      end
   end

   // Only symbols below the radix take part; every pair is compared.
   always_comb begin
      sym_bad = 1'b0;
      dup     = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (RADIX_BITS'(i) < radix) begin
            if (sym[i] == PLUS_SIGN || sym[i] == MINUS_SIGN ||
                sym[i] < LOW_PRINTABLE || sym[i] >= HIGH_LIMIT) begin
               sym_bad = 1'b1;
            end
            for (int j = i + 1; j < SLOTS; j++) begin
               if (RADIX_BITS'(j) < radix && sym[j] == sym[i]) begin
                  dup = 1'b1;
               end
            end
         end
      end
   end

   assign alpha_ok = (radix >= RADIX_BITS'(2)) &&
                     (radix <= RADIX_BITS'(MAX_RADIX)) &&
                     (radix <= RADIX_BITS'(SLOTS)) &&
                     !sym_bad && !dup;

endmodule

@@ hw/rtl/sitrd_divider.sv @@
// ----------------------------------------------------------------------------
// sitrd_divider
// Restoring divider, one quotient bit per cycle, by a small radix.
// ----------------------------------------------------------------------------
module sitrd_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sitrd_pkg::VALUE_BITS-1:0] dividend,
   input  logic [sitrd_pkg::RADIX_BITS-1:0] divisor,
   output logic                             done,
   output logic [sitrd_pkg::VALUE_BITS-1:0] quotient,
   output logic [sitrd_pkg::DIGIT_BITS-1:0] remainder
);
   import sitrd_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [VALUE_BITS-1:0] quot_ff;
   logic [DIGIT_BITS-1:0] rem_ff;
   logic [RADIX_BITS-1:0] div_ff;

   logic [RADIX_BITS-1:0] trial;
   logic [RADIX_BITS-1:0] diff;
   logic                  qbit;
   logic [VALUE_BITS-1:0] quot_in;
   logic [DIGIT_BITS-1:0] rem_in;

   // The remainder stays below the divisor, so it fits one digit.
   always_comb begin
      trial   = {rem_ff, quot_ff[VALUE_BITS-1]};
      diff    = trial - div_ff;
      qbit    = (trial >= div_ff);
      rem_in  = qbit ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
      quot_in = {quot_ff[VALUE_BITS-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_BITS'(VALUE_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/sitrd_digit_stack.sv @@
// ----------------------------------------------------------------------------
// sitrd_digit_stack
// Last-in first-out store that reverses digits into print order.
// ----------------------------------------------------------------------------
module sitrd_digit_stack (
   input  logic                             clock,
   input  logic                             reset,
   input  sitrd_pkg::stk_ctrl_type          ctrl,
   input  logic [sitrd_pkg::DIGIT_BITS-1:0] push_digit,
   output logic [sitrd_pkg::DIGIT_BITS-1:0] top_digit,
   output logic [sitrd_pkg::CNT_BITS-1:0]   count
);
   import sitrd_pkg::*;

   logic [DIGIT_BITS-1:0] entry_ff [STACK_DEPTH];
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   top_idx;

   assign top_idx = count_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.push) begin
         count_ff <= count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         entry_ff[count_ff[PTR_BITS-1:0]] <= push_digit;
      end
   end

   assign top_digit = entry_ff[top_idx[PTR_BITS-1:0]];
   assign count     = count_ff;

endmodule

@@ hw/rtl/signed_int_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits
// Converts a signed number to its text in a configurable radix.
// ----------------------------------------------------------------------------
// Usage: program radix, digits_low and digits_high through the csr_ port
// while the block is idle. Each req_ beat carries one signed value; the
// block answers with one rsp_ beat per character: a leading minus sign for
// negative values, then the digits most significant first, with rsp_last
// set on the final character. With an invalid alphabet the beat is taken
// and no characters come out.
// Timing: each digit costs one divide by the radix on the shared
// bit-serial divider: a load, one step per quotient bit, then a hand-off.
// The characters then leave at one per cycle from the output register
// while the receiver takes them. req_ready is high only while no item is
// in progress. Reset clears the configuration registers to zero, which
// leaves the alphabet invalid, and empties the digit stack. When the
// receiver stalls, the current character holds in the output register and
// the block waits.
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [sitrd_pkg::VALUE_BITS-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sitrd_pkg::SYM_BITS-1:0]       rsp_symbol,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [sitrd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sitrd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import sitrd_pkg::*;

`include "assert_macros.svh"

   logic [RADIX_BITS-1:0] radix_ff;
   logic [WORD_BITS-1:0]  digits_low_ff;
   logic [WORD_BITS-1:0]  digits_high_ff;

   state_type             state_ff;
   state_type             state_in;
   logic [VALUE_BITS-1:0] mag_ff;
   logic                  neg_ff;
   logic                  rsp_valid_ff;
   logic [SYM_BITS-1:0]   rsp_symbol_ff;
   logic                  rsp_last_ff;

   logic                  alpha_ok;
   logic                  accept;
   logic                  slot_free;
   logic                  sign_load;
   logic                  div_start;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [DIGIT_BITS-1:0] div_remainder;
   stk_ctrl_type          stk;
   logic [DIGIT_BITS-1:0] stk_top;
   logic [CNT_BITS-1:0]   stk_count;
   logic                  last_pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= '0;
         digits_low_ff  <= '0;
         digits_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIX:       radix_ff       <= csr_wdata[RADIX_BITS-1:0];
            CSR_DIGITS_LOW:  digits_low_ff  <= csr_wdata[WORD_BITS-1:0];
            CSR_DIGITS_HIGH: digits_high_ff <= csr_wdata[WORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   sitrd_alpha_check u_check (
      .radix       (radix_ff),
      .digits_low  (digits_low_ff),
      .digits_high (digits_high_ff),
      .alpha_ok    (alpha_ok)
   );

   sitrd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_ff),
      .divisor   (radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   sitrd_digit_stack u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (stk),
      .push_digit (div_remainder),
      .top_digit  (stk_top),
      .count      (stk_count)
   );

   // Sequencer outputs.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      slot_free = !rsp_valid_ff || rsp_ready;
      div_start = (state_ff == ST_DIV_LOAD);
      stk.push  = (state_ff == ST_DIV_RUN) && div_done;
      stk.pop   = (state_ff == ST_EMIT) && slot_free;
      sign_load = (state_ff == ST_SIGN) && slot_free;
      last_pop  = stk.pop && (stk_count == CNT_BITS'(1));
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && alpha_ok) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               if (div_quotient != '0) begin
                  state_in = ST_DIV_LOAD;
               end else if (neg_ff) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (last_pop) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (stk.pop || sign_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The most negative value comes out right as an unsigned magnitude.
   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff <= req_value[VALUE_BITS-1];
         mag_ff <= req_value[VALUE_BITS-1] ? ('0 - req_value) : req_value;
      end else if (stk.push) begin
         mag_ff <= div_quotient;
      end
      if (sign_load) begin
         rsp_symbol_ff <= MINUS_SIGN;
         rsp_last_ff   <= 1'b0;
      end else if (stk.pop) begin
         rsp_symbol_ff <= symbol_at(digits_low_ff, digits_high_ff, stk_top);
         rsp_last_ff   <= (stk_count == CNT_BITS'(1));
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   `ASSERT_NEVER(a_idle_stack_empty, clock, reset, state_ff == ST_IDLE && stk_count != '0)
   `ASSERT_NEVER(a_emit_has_digit, clock, reset, state_ff == ST_EMIT && stk_count == '0)
   `ASSERT_IMPL(a_done_in_run, clock, reset, div_done |-> state_ff == ST_DIV_RUN)
   `ASSERT_IMPL(a_last_ends_item, clock, reset, last_pop |=> rsp_last && state_ff == ST_IDLE)

endmodule

@@ verif/signed_int_to_radix_digits_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits_checker
// Watches the value, character and register ports of the radix text
// converter, predicts the characters of every accepted value and compares
// them in order with the characters that leave the block.
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic signed [sitrd_pkg::VALUE_BITS-1:0]  req_value,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic [sitrd_pkg::SYM_BITS-1:0]           rsp_symbol,
   input  logic                                     rsp_last,
   input  logic                                     csr_we,
   input  logic [sitrd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sitrd_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output int                                       error_count,
   output int                                       chars_outstanding
);
   import sitrd_pkg::*;

   typedef struct {
      logic [SYM_BITS-1:0] symbol;
      logic                last;
   } text_char_type;

   logic [RADIX_BITS-1:0] radix_reg;
   logic [WORD_BITS-1:0]  digits_lo_reg;
   logic [WORD_BITS-1:0]  digits_hi_reg;
   text_char_type         expected_chars[$];
   int                    errors = 0;
   int                    pending = 0;

   assign error_count = errors;
   assign chars_outstanding = pending;

   function automatic logic [SYM_BITS-1:0] alphabet_symbol(input int unsigned k);
      logic [WORD_BITS-1:0] word;
      word = (k < HALF_SLOTS) ? digits_lo_reg : digits_hi_reg;
      return SYM_BITS'(word >> ((k % HALF_SLOTS) * SYM_BITS));
   endfunction

   function automatic bit alphabet_valid();
      int unsigned         n;
      logic [SYM_BITS-1:0] c;
      n = radix_reg;
      if (n < 2 || n > MAX_RADIX || n > SLOTS) return 1'b0;
      for (int i = 0; i < n; i++) begin
         c = alphabet_symbol(i);
         if (c == PLUS_SIGN || c == MINUS_SIGN || c < LOW_PRINTABLE || c >= HIGH_LIMIT)
            return 1'b0;
         for (int j = i + 1; j < n; j++)
            if (alphabet_symbol(j) == c) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Queues the characters of one value: sign first, then digits from the top.
   function automatic void predict_text(input logic signed [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] magnitude;
      logic [DIGIT_BITS-1:0] digit_stack[$];
      logic [DIGIT_BITS-1:0] d;
      text_char_type         c;
      if (!alphabet_valid()) return;
      // Two's complement negation keeps the most negative value as its
      // unsigned magnitude.
      magnitude = value;
      if (value[VALUE_BITS-1]) magnitude = ~magnitude + 1'b1;
      do begin
         digit_stack.push_back(DIGIT_BITS'(magnitude % radix_reg));
         magnitude = magnitude / radix_reg;
      end while (magnitude != 0);
      if (value[VALUE_BITS-1]) begin
         c.symbol = MINUS_SIGN;
         c.last = 1'b0;
         expected_chars.push_back(c);
      end
      while (digit_stack.size() > 0) begin
         d = digit_stack.pop_back();
         c.symbol = alphabet_symbol(d);
         c.last = (digit_stack.size() == 0);
         expected_chars.push_back(c);
      end
   endfunction

   always @(posedge clock) begin : watch
      text_char_type want;
      if (reset) begin
         radix_reg = '0;
         digits_lo_reg = '0;
         digits_hi_reg = '0;
         expected_chars.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RADIX: begin
                  radix_reg = csr_wdata[RADIX_BITS-1:0];
               end
               CSR_DIGITS_LOW: begin
                  digits_lo_reg = csr_wdata;
               end
               CSR_DIGITS_HIGH: begin
                  digits_hi_reg = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected character beat, expected none, actual %h last %b",
                        $time, rsp_symbol, rsp_last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_symbol !== want.symbol) begin
                  errors++;
                  $display("%0t: rsp_symbol mismatch, expected %h, actual %h",
                           $time, want.symbol, rsp_symbol);
               end
               if (rsp_last !== want.last) begin
                  errors++;
                  $display("%0t: rsp_last mismatch, expected %b, actual %b",
                           $time, want.last, rsp_last);
               end
            end
         end
         // Predicted after the compare so that a stray beat on the same edge
         // cannot match a fresh expectation.
         if (req_valid && req_ready) predict_text(req_value);
      end
      pending <= expected_chars.size();
   end

endmodule

@@ verif/signed_int_to_radix_digits_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits_tb
// Drives values and alphabets into the radix text converter with random
// gaps and stalls; a separate checker predicts and compares every character.
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits_tb;
   import sitrd_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   // Slowest value: 32 binary digits, each one full divide, plus the output.
   localparam int DRAIN_CYCLES = 1200;
   localparam int RADIX_TOP = (1 << RADIX_BITS) - 1;
   localparam logic signed [VALUE_BITS-1:0] MIN_VALUE = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] MAX_VALUE = {1'b0, {(VALUE_BITS-1){1'b1}}};

   typedef enum {
      BREAK_RADIX_LOW,
      BREAK_RADIX_HIGH,
      BREAK_SYMBOL,
      BREAK_DUPLICATE
   } alphabet_fault_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic signed [VALUE_BITS-1:0]  req_value = '0;
   logic                          rsp_ready = 1'b0;
   logic                          csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;
   logic                          req_ready;
   logic                          rsp_valid;
   logic [SYM_BITS-1:0]           rsp_symbol;
   logic                          rsp_last;
   int                            error_count;
   int                            chars_outstanding;
   bit                            no_idle = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   signed_int_to_radix_digits uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   signed_int_to_radix_digits_checker text_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_symbol        (rsp_symbol),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .error_count       (error_count),
      .chars_outstanding (chars_outstanding)
   );

   function automatic logic [2*WORD_BITS-1:0] pack_symbols(input string text);
      logic [2*WORD_BITS-1:0] syms;
      syms = '0;
      for (int k = 0; k < text.len() && k < SLOTS; k++)
         syms[k*SYM_BITS +: SYM_BITS] = text[k];
      return syms;
   endfunction

   // Distinct legal symbols in the first n slots, random bytes in the rest.
   function automatic logic [2*WORD_BITS-1:0] random_alphabet(input int unsigned n);
      logic [2*WORD_BITS-1:0] syms;
      logic [SYM_BITS-1:0]    c;
      bit                     clash;
      for (int k = 0; k < SLOTS; k++)
         syms[k*SYM_BITS +: SYM_BITS] = SYM_BITS'($urandom);
      for (int k = 0; k < n; k++) begin
         do begin
            c = SYM_BITS'($urandom_range(LOW_PRINTABLE, HIGH_LIMIT - 1));
            clash = (c == PLUS_SIGN || c == MINUS_SIGN);
            for (int j = 0; j < k; j++)
               if (syms[j*SYM_BITS +: SYM_BITS] == c) clash = 1'b1;
         end while (clash);
         syms[k*SYM_BITS +: SYM_BITS] = c;
      end
      return syms;
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value(input int unsigned base);
      longint                       power;
      logic signed [VALUE_BITS-1:0] v;
      case ($urandom_range(0, 5))
         0, 1: begin
            v = $urandom;
         end
         2: begin
            v = $urandom_range(0, 3 * base);
            if ($urandom_range(0, 1)) v = -v;
         end
         3: begin
            case ($urandom_range(0, 3))
               0: v = MIN_VALUE;
               1: v = MAX_VALUE;
               2: v = '0;
               default: v = '1;
            endcase
         end
         4: begin
            // Around a power of the radix, where the digit count steps.
            power = 1;
            repeat ($urandom_range(1, VALUE_BITS - 1))
               if (power * base < 64'h8000_0000) power = power * base;
            v = power[VALUE_BITS-1:0];
            v = v + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) v = -v;
         end
         default: begin
            v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Register writes go out on back-to-back edges; the stray write to the
   // unused index must leave the alphabet alone.
   task automatic load_alphabet(input logic [RADIX_BITS-1:0] radix,
                                input logic [2*WORD_BITS-1:0] syms,
                                input bit stray);
      logic [CSR_DATA_BITS-1:0] word;
      word = {$urandom, $urandom};
      word[RADIX_BITS-1:0] = radix;
      csr_we <= 1'b1;
      csr_index <= CSR_RADIX;
      csr_wdata <= word;
      @(posedge clock);
      csr_index <= CSR_DIGITS_LOW;
      csr_wdata <= syms[WORD_BITS-1:0];
      @(posedge clock);
      csr_index <= CSR_DIGITS_HIGH;
      csr_wdata <= syms[2*WORD_BITS-1:WORD_BITS];
      @(posedge clock);
      if (stray) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Values under a bad alphabet are dropped at once; the extra wait only
   // leaves a quiet margin before the next register write.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chars_outstanding != 0 || !req_ready) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic expect_silence(input logic [RADIX_BITS-1:0] radix,
                                 input logic [2*WORD_BITS-1:0] syms);
      load_alphabet(radix, syms, 1'b0);
      send_value($urandom);
      drain();
   endtask

   initial begin : char_sink
      int stall;
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [RADIX_BITS-1:0]  radix;
      logic [2*WORD_BITS-1:0] syms;
      alphabet_fault_type     fault;
      int unsigned            i;
      int unsigned            j;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Registers leave reset at zero, so these values produce no text.
      send_value(0);
      send_value(-5);
      drain();

      load_alphabet(10, pack_symbols("0123456789"), 1'b1);
      send_value(0);
      send_value(1);
      send_value(-1);
      send_value(9);
      send_value(10);
      send_value(-10);
      send_value(MAX_VALUE);
      send_value(MIN_VALUE);
      drain();

      load_alphabet(2, pack_symbols("01"), 1'b0);
      send_value(MIN_VALUE);
      send_value(MAX_VALUE);
      send_value(0);
      send_value(-1);
      send_value(5);
      drain();

      load_alphabet(RADIX_BITS'(MAX_RADIX), pack_symbols("0123456789ABCDEF"), 1'b0);
      send_value(255);
      send_value(-256);
      send_value(MAX_VALUE);
      send_value(MIN_VALUE);
      send_value(0);
      drain();

      // Space and tilde are the printable limits; the bytes past the radix
      // hold a minus, a plus and zeros and must be ignored.
      load_alphabet(3, pack_symbols(" ~a-+"), 1'b0);
      send_value(-7);
      send_value(8);
      drain();

      expect_silence(1, pack_symbols("0123456789"));
      expect_silence(RADIX_BITS'(MAX_RADIX + 1), random_alphabet(SLOTS));
      expect_silence(RADIX_BITS'(RADIX_TOP), random_alphabet(SLOTS));
      expect_silence(2, pack_symbols("0+"));
      expect_silence(2, pack_symbols("-1"));
      syms = pack_symbols("01");
      syms[SYM_BITS-1:0] = LOW_PRINTABLE - 1;
      expect_silence(2, syms);
      syms = pack_symbols("01");
      syms[2*SYM_BITS-1:SYM_BITS] = HIGH_LIMIT;
      expect_silence(2, syms);
      // Equal symbols that are not neighbors.
      expect_silence(4, pack_symbols("0120"));

      for (int phase = 0; phase < 11; phase++) begin
         no_idle = ($urandom_range(0, 3) == 0);
         radix = (phase == 0) ? RADIX_BITS'(2) :
                 (phase == 1) ? RADIX_BITS'(MAX_RADIX) :
                 RADIX_BITS'($urandom_range(2, MAX_RADIX));
         syms = random_alphabet(radix);
         if (phase % 5 == 4) begin
            fault = alphabet_fault_type'($urandom_range(0, 3));
            case (fault)
               BREAK_RADIX_LOW: begin
                  radix = RADIX_BITS'($urandom_range(0, 1));
               end
               BREAK_RADIX_HIGH: begin
                  radix = RADIX_BITS'($urandom_range(MAX_RADIX + 1, RADIX_TOP));
               end
               BREAK_SYMBOL: begin
                  i = $urandom_range(0, radix - 1);
                  case ($urandom_range(0, 3))
                     0: syms[i*SYM_BITS +: SYM_BITS] = PLUS_SIGN;
                     1: syms[i*SYM_BITS +: SYM_BITS] = MINUS_SIGN;
                     2: syms[i*SYM_BITS +: SYM_BITS] =
                           SYM_BITS'($urandom_range(0, LOW_PRINTABLE - 1));
                     default: syms[i*SYM_BITS +: SYM_BITS] =
                           SYM_BITS'($urandom_range(HIGH_LIMIT, 255));
                  endcase
               end
               default: begin
                  i = $urandom_range(0, radix - 2);
                  j = $urandom_range(i + 1, radix - 1);
                  syms[j*SYM_BITS +: SYM_BITS] = syms[i*SYM_BITS +: SYM_BITS];
               end
            endcase
            load_alphabet(radix, syms, 1'($urandom_range(0, 1)));
            repeat (3) send_value($urandom);
         end else begin
            load_alphabet(radix, syms, $urandom_range(0, 3) == 0);
            repeat (32) send_value(pick_value(radix));
         end
         drain();
      end

      if (error_count == 0 && chars_outstanding == 0) begin
         $display("signed_int_to_radix_digits_tb passed");
      end else begin
         $display("signed_int_to_radix_digits_tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #16_000_000;
      $display("signed_int_to_radix_digits_tb failed");
      $finish;
   end

endmodule

@@ signed_int_to_radix_digits.f @@
+incdir+hw/rtl
hw/rtl/sitrd_pkg.sv
hw/rtl/sitrd_alpha_check.sv
hw/rtl/sitrd_divider.sv
hw/rtl/sitrd_digit_stack.sv
hw/rtl/signed_int_to_radix_digits.sv
verif/signed_int_to_radix_digits_checker.sv
verif/signed_int_to_radix_digits_tb.sv
